// ===== rtl/core/ldp_pkg.sv =====
// ldp_pkg: types, widths and codes shared by the lorentz-drude permittivity core
// no dependencies; imported by the interfaces, cells, arithmetic units and top level

package ldp_pkg;

    // default parameter values
    localparam int MAX_OSC_DEF = 8;
    localparam int FREQ_W_DEF  = 24;

    // internal q4.16 frequency format
    localparam int INT_W  = 20;
    localparam int SEL_W  = 3;
    localparam int CNT_W  = 4;
    localparam int IDX_W  = 3;
    localparam int OUT_W  = 40;

    // denominator and term datapath widths
    localparam int SQ_W   = 2 * INT_W;       // squares and products, q8.32
    localparam int DEN_S_W = 43;             // signed real / imaginary denominator part
    localparam int ABS_W  = 42;              // magnitude of a denominator part
    localparam int DEN_W  = 84;              // ar^2 + ai^2
    localparam int NUM_W  = 60;              // strength * plasma^2

    // serial multiplier
    localparam int MUL_A_W   = 60;
    localparam int MUL_B_W   = 42;
    localparam int MUL_CHUNK = 14;
    localparam int MUL_STEPS = MUL_B_W / MUL_CHUNK;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    // divider: quotient bits kept below the overflow check
    localparam int DIV_Q_W = 41;
    localparam int REM_W   = DEN_W + 1;
    localparam logic [DIV_Q_W-1:0] TERM_CLAMP = {1'b1, {(DIV_Q_W-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_PLASMA    = 3'd0,
        CFG_COUNT     = 3'd1,
        CFG_SELECT    = 3'd2,
        CFG_STRENGTH  = 3'd3,
        CFG_RESONANCE = 3'd4,
        CFG_DAMPING   = 3'd5
    } t_cfg_reg;

    // one oscillator table entry, internal format
    typedef struct packed {
        logic [INT_W-1:0] f;
        logic [INT_W-1:0] r;
        logic [INT_W-1:0] g;
    } t_osc_entry;

    // entry write request to the oscillator ring
    typedef struct packed {
        logic             str;
        logic             res;
        logic             dmp;
        logic [SEL_W-1:0] sel;
        logic [INT_W-1:0] data;
    } t_osc_wr;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_TERM_A,
        ST_TERM_B,
        ST_MUL_AR,
        ST_MUL_AI,
        ST_MUL_NUM,
        ST_MUL_PR,
        ST_DIV_R,
        ST_MUL_PI,
        ST_DIV_I,
        ST_NEXT,
        ST_ROT,
        ST_DONE
    } t_ldp_state;

endpackage

// ===== rtl/core/ldp_if.sv =====
// ldp_if: valid/ready channel interfaces of the permittivity core
// depends on ldp_pkg for the result and register index widths

interface ldp_in_if import ldp_pkg::*; #(parameter int FREQ_WIDTH = FREQ_W_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [FREQ_WIDTH-1:0] omega_re;
    logic signed [FREQ_WIDTH-1:0] omega_im;

    modport source (output valid, output omega_re, output omega_im, input ready);
    modport sink   (input valid, input omega_re, input omega_im, output ready);
endinterface

interface ldp_out_if import ldp_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] eps_re;
    logic signed [OUT_W-1:0] eps_im;
    logic                    saturated;

    modport source (output valid, output eps_re, output eps_im, output saturated, input ready);
    modport sink   (input valid, input eps_re, input eps_im, input saturated, output ready);
endinterface

interface ldp_cfg_if import ldp_pkg::*; #(parameter int FREQ_WIDTH = FREQ_W_DEF);
    logic                  valid;
    logic                  ready;
    logic [IDX_W-1:0]      index;
    logic [FREQ_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ldp_osc_cell.sv =====
// ldp_osc_cell: one oscillator table entry, a link of the rotating entry ring
// depends on ldp_pkg for the entry and write request types

module ldp_osc_cell import ldp_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  t_osc_wr    i_wr,
    input  t_osc_entry i_next,
    output t_osc_entry o_entry
);

    t_osc_entry r_entry;
    logic       w_hit;

    assign w_hit   = (int'(i_wr.sel) == IDX);
    assign o_entry = r_entry;

    // take the neighbor's entry on a shift, otherwise accept register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_next;
        end else if (w_hit) begin
            if (i_wr.str) r_entry.f <= i_wr.data;
            if (i_wr.res) r_entry.r <= i_wr.data;
            if (i_wr.dmp) r_entry.g <= i_wr.data;
        end
    end

endmodule

// ===== rtl/core/ldp_serial_mul.sv =====
// ldp_serial_mul: unsigned multiplier taking the second operand a chunk per cycle
// depends on ldp_pkg for operand widths

module ldp_serial_mul import ldp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_p,
    output logic               o_done
);

    localparam int PP_W  = MUL_A_W + MUL_CHUNK;
    localparam int STP_W = $clog2(MUL_STEPS + 1);

    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [MUL_P_W-1:0] r_acc;
    logic [STP_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [PP_W-1:0]    w_pp;

    // partial product of the top chunk
    assign w_pp   = r_a * r_b[MUL_B_W-1 -: MUL_CHUNK];
    assign o_p    = r_acc;
    assign o_done = r_done;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STP_W'(MUL_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift-accumulate datapath, msb chunk first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= r_b << MUL_CHUNK;
            r_acc <= (r_acc << MUL_CHUNK) + MUL_P_W'(w_pp);
        end
    end

endmodule

// ===== rtl/core/ldp_divider.sv =====
// ldp_divider: restoring divider, one quotient bit per cycle, clamped at 2^40
// depends on ldp_pkg for numerator, denominator and quotient widths

module ldp_divider import ldp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_P_W-1:0] i_num,
    input  logic [DEN_W-1:0]   i_den,
    output logic [DIV_Q_W-1:0] o_mag,
    output logic               o_clamp,
    output logic               o_done
);

    localparam int CNT_DW = $clog2(DIV_Q_W + 1);
    localparam int CMP_W  = DEN_W + DIV_Q_W;

    logic [REM_W-1:0]   r_rem;
    logic [DIV_Q_W-1:0] r_q;
    logic [DEN_W-1:0]   r_den;
    logic [CNT_DW-1:0]  r_cnt;
    logic               r_busy;
    logic               r_done;
    logic               r_ovf;
    logic [REM_W-1:0]   w_trial;
    logic [REM_W-1:0]   w_den_x;
    logic               w_ge;

    // one restoring step
    assign w_trial = {r_rem[REM_W-2:0], r_q[DIV_Q_W-1]};
    assign w_den_x = REM_W'(r_den);
    assign w_ge    = (w_trial >= w_den_x);

    // clamp when the quotient passes 2^40
    assign o_clamp = r_ovf || (r_q > TERM_CLAMP);
    assign o_mag   = o_clamp ? TERM_CLAMP : r_q;
    assign o_done  = r_done;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_DW'(DIV_Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_DW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // high numerator bits seed the remainder, low bits shift in as quotient forms
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_ovf <= (CMP_W'(i_num) >= {i_den, {DIV_Q_W{1'b0}}});
            r_rem <= REM_W'(i_num[MUL_P_W-1:DIV_Q_W]);
            r_q   <= i_num[DIV_Q_W-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_trial - w_den_x) : w_trial;
            r_q   <= {r_q[DIV_Q_W-2:0], w_ge};
        end
    end

endmodule

// ===== rtl/core/lorentz_drude_permittivity_core.sv =====
// Lorentz-Drude permittivity core. Each word on the input channel is one complex
// frequency, and one result word follows with the summed oscillator permittivity. Items
// are taken one at a time. An accepted word first has its frequency squares formed, then
// for each active oscillator: the denominator parts, five chunked multiplies, two passes
// of the bit-serial divider (41 quotient steps each) and a shift of the ring. The ring
// then turns on until it has made MAX_OSCILLATORS shifts in all, so that every entry is
// back home. The done state loads the result, and the input is ready again in the next
// cycle; a stall on the result side holds the core in the done state. A zero denominator
// cuts the oscillator loop short. The configuration port holds its ready high. The user
// must let configuration writes go in only while no item is in flight; the core itself
// does not enforce it.
// depends on ldp_pkg, ldp_if, ldp_osc_cell, ldp_serial_mul, ldp_divider

module lorentz_drude_permittivity_core import ldp_pkg::*; #(
    parameter int MAX_OSCILLATORS = MAX_OSC_DEF,
    parameter int FREQ_WIDTH      = FREQ_W_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ldp_cfg_if.sink   i_cfg,
    ldp_in_if.sink    i_in,
    ldp_out_if.source o_out
);

    localparam int ROT_W = $clog2(MAX_OSCILLATORS + 1);
    localparam int ACC_W = DIV_Q_W + $clog2(MAX_OSCILLATORS) + 2;
    localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI - ACC_W'(1);

    t_ldp_state r_state, n_state;

    // configuration registers
    logic [INT_W-1:0] r_plasma;
    logic [CNT_W-1:0] r_osc_count;
    logic [SEL_W-1:0] r_osc_select;

    // format conversion to q4.16
    logic [INT_W-1:0]        w_cfg_int;
    logic signed [INT_W-1:0] w_in_re;
    logic signed [INT_W-1:0] w_in_im;

    if (FREQ_WIDTH >= INT_W) begin : g_cut
        assign w_cfg_int = i_cfg.data[FREQ_WIDTH-1 -: INT_W];
        assign w_in_re   = i_in.omega_re[FREQ_WIDTH-1 -: INT_W];
        assign w_in_im   = i_in.omega_im[FREQ_WIDTH-1 -: INT_W];
    end else begin : g_pad
        assign w_cfg_int = {i_cfg.data, {(INT_W-FREQ_WIDTH){1'b0}}};
        assign w_in_re   = {i_in.omega_re, {(INT_W-FREQ_WIDTH){1'b0}}};
        assign w_in_im   = {i_in.omega_im, {(INT_W-FREQ_WIDTH){1'b0}}};
    end

    // configuration port
    logic    w_cfg_we;
    t_osc_wr w_osc_wr;

    assign i_cfg.ready   = 1'b1;
    assign w_cfg_we      = i_cfg.valid;
    assign w_osc_wr.str  = w_cfg_we && (i_cfg.index == CFG_STRENGTH);
    assign w_osc_wr.res  = w_cfg_we && (i_cfg.index == CFG_RESONANCE);
    assign w_osc_wr.dmp  = w_cfg_we && (i_cfg.index == CFG_DAMPING);
    assign w_osc_wr.sel  = r_osc_select;
    assign w_osc_wr.data = w_cfg_int;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plasma     <= '0;
            r_osc_count  <= '0;
            r_osc_select <= '0;
        end else if (w_cfg_we) begin
            case (i_cfg.index)
                CFG_PLASMA: r_plasma     <= w_cfg_int;
                CFG_COUNT:  r_osc_count  <= i_cfg.data[CNT_W-1:0];
                CFG_SELECT: r_osc_select <= i_cfg.data[SEL_W-1:0];
                default: ;
            endcase
        end
    end

    // oscillator ring, entry j reaches the head after j shifts
    logic       w_shift;
    t_osc_entry w_ring [MAX_OSCILLATORS];
    t_osc_entry w_head;

    for (genvar k = 0; k < MAX_OSCILLATORS; k++) begin : g_cell
        ldp_osc_cell #(.IDX(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_wr    (w_osc_wr),
            .i_next  (w_ring[(k + 1) % MAX_OSCILLATORS]),
            .o_entry (w_ring[k])
        );
    end

    assign w_head = w_ring[0];

    // shared arithmetic units
    logic               w_mul_start;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [MUL_P_W-1:0] w_mul_p;
    logic               w_mul_done;
    logic               w_div_start;
    logic [DIV_Q_W-1:0] w_div_mag;
    logic               w_div_clamp;
    logic               w_div_done;

    logic [MUL_P_W-1:0] r_prod;
    logic [DEN_W-1:0]   r_den;

    ldp_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_p     (w_mul_p),
        .o_done  (w_mul_done)
    );

    ldp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_mag   (w_div_mag),
        .o_clamp (w_div_clamp),
        .o_done  (w_div_done)
    );

    // item datapath registers
    logic signed [INT_W-1:0]   r_wr, r_wi;
    logic signed [SQ_W-1:0]    r_wr2, r_wi2, r_wrwi;
    logic [SQ_W-1:0]           r_wp2, r_r2;
    logic signed [SQ_W:0]      r_gwi, r_gwr;
    logic [INT_W-1:0]          r_f;
    logic [ABS_W-1:0]          r_ar, r_ai;
    logic                      r_neg_re, r_neg_im;
    logic [NUM_W-1:0]          r_num;
    logic signed [ACC_W-1:0]   r_acc_re, r_acc_im;
    logic                      r_flag, r_zero, r_go;
    logic [ROT_W-1:0]          r_j, r_rot, w_nact;
    logic signed [DEN_S_W-1:0] w_dre, w_dim;
    logic signed [ACC_W-1:0]   w_term;

    // output register
    logic                    r_ov;
    logic signed [OUT_W-1:0] r_eps_re, r_eps_im;
    logic                    r_sat;
    logic                    w_load;

    assign o_out.valid     = r_ov;
    assign o_out.eps_re    = r_eps_re;
    assign o_out.eps_im    = r_eps_im;
    assign o_out.saturated = r_sat;
    assign i_in.ready      = (r_state == ST_IDLE);

    // active oscillator count, capped at table size
    assign w_nact = (int'(r_osc_count) > MAX_OSCILLATORS) ?
                    ROT_W'(MAX_OSCILLATORS) : ROT_W'(r_osc_count);

    // denominator parts: r^2 - w^2 + i*w*g
    assign w_dre = DEN_S_W'($signed({1'b0, r_r2})) - DEN_S_W'(r_wr2) + DEN_S_W'(r_wi2)
                 - DEN_S_W'(r_gwi);
    assign w_dim = DEN_S_W'(r_gwr) - DEN_S_W'($signed({r_wrwi, 1'b0}));

    // signed term from the divider magnitude
    assign w_term = $signed(ACC_W'(w_div_mag));

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and unit controls
    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        w_shift     = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) n_state = ST_PRE;
            end
            ST_PRE: begin
                n_state = (w_nact == '0) ? ST_ROT : ST_TERM_A;
            end
            ST_TERM_A: begin
                n_state = ST_TERM_B;
            end
            ST_TERM_B: begin
                n_state = (w_dre == '0 && w_dim == '0) ? ST_ROT : ST_MUL_AR;
            end
            ST_MUL_AR: begin
                w_mul_start = !r_go;
                w_mul_a     = MUL_A_W'(r_ar);
                w_mul_b     = r_ar;
                if (r_go && w_mul_done) n_state = ST_MUL_AI;
            end
            ST_MUL_AI: begin
                w_mul_start = !r_go;
                w_mul_a     = MUL_A_W'(r_ai);
                w_mul_b     = r_ai;
                if (r_go && w_mul_done) n_state = ST_MUL_NUM;
            end
            ST_MUL_NUM: begin
                w_mul_start = !r_go;
                w_mul_a     = MUL_A_W'(r_wp2);
                w_mul_b     = MUL_B_W'(r_f);
                if (r_go && w_mul_done) n_state = ST_MUL_PR;
            end
            ST_MUL_PR: begin
                w_mul_start = !r_go;
                w_mul_a     = r_num;
                w_mul_b     = r_ar;
                if (r_go && w_mul_done) n_state = ST_DIV_R;
            end
            ST_DIV_R: begin
                w_div_start = !r_go;
                if (r_go && w_div_done) n_state = ST_MUL_PI;
            end
            ST_MUL_PI: begin
                w_mul_start = !r_go;
                w_mul_a     = r_num;
                w_mul_b     = r_ai;
                if (r_go && w_mul_done) n_state = ST_DIV_I;
            end
            ST_DIV_I: begin
                w_div_start = !r_go;
                if (r_go && w_div_done) n_state = ST_NEXT;
            end
            ST_NEXT: begin
                w_shift = 1'b1;
                n_state = (r_j + 1'b1 == w_nact) ? ST_ROT : ST_TERM_A;
            end
            ST_ROT: begin
                if (r_rot == ROT_W'(MAX_OSCILLATORS)) begin
                    n_state = ST_DONE;
                end else begin
                    w_shift = 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_ov || o_out.ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // handshake flag for the shared units and ring position counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go  <= 1'b0;
            r_rot <= '0;
            r_j   <= '0;
        end else begin
            if (w_mul_start || w_div_start) begin
                r_go <= 1'b1;
            end else if (w_mul_done || w_div_done) begin
                r_go <= 1'b0;
            end
            if (r_state == ST_PRE) begin
                r_rot <= '0;
                r_j   <= '0;
            end else if (w_shift) begin
                r_rot <= r_rot + 1'b1;
                if (r_state == ST_NEXT) r_j <= r_j + 1'b1;
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_wr     <= w_in_re;
                r_wi     <= w_in_im;
                r_acc_re <= '0;
                r_acc_im <= '0;
                r_flag   <= 1'b0;
                r_zero   <= 1'b0;
            end
            ST_PRE: begin
                r_wr2  <= r_wr * r_wr;
                r_wi2  <= r_wi * r_wi;
                r_wrwi <= r_wr * r_wi;
                r_wp2  <= r_plasma * r_plasma;
            end
            ST_TERM_A: begin
                r_f   <= w_head.f;
                r_r2  <= w_head.r * w_head.r;
                r_gwi <= $signed({1'b0, w_head.g}) * r_wi;
                r_gwr <= $signed({1'b0, w_head.g}) * r_wr;
            end
            ST_TERM_B: begin
                r_neg_re <= w_dre[DEN_S_W-1];
                r_neg_im <= w_dim[DEN_S_W-1];
                r_ar     <= w_dre[DEN_S_W-1] ? ABS_W'(-w_dre) : ABS_W'(w_dre);
                r_ai     <= w_dim[DEN_S_W-1] ? ABS_W'(-w_dim) : ABS_W'(w_dim);
                if (w_dre == '0 && w_dim == '0) r_zero <= 1'b1;
            end
            ST_MUL_AR: begin
                if (r_go && w_mul_done) r_den <= w_mul_p[DEN_W-1:0];
            end
            ST_MUL_AI: begin
                if (r_go && w_mul_done) r_den <= r_den + w_mul_p[DEN_W-1:0];
            end
            ST_MUL_NUM: begin
                if (r_go && w_mul_done) r_num <= w_mul_p[NUM_W-1:0];
            end
            ST_MUL_PR, ST_MUL_PI: begin
                if (r_go && w_mul_done) r_prod <= w_mul_p;
            end
            ST_DIV_R: begin
                if (r_go && w_div_done) begin
                    r_acc_re <= r_neg_re ? r_acc_re - w_term : r_acc_re + w_term;
                    if (w_div_clamp) r_flag <= 1'b1;
                end
            end
            ST_DIV_I: begin
                if (r_go && w_div_done) begin
                    r_acc_im <= r_neg_im ? r_acc_im + w_term : r_acc_im - w_term;
                    if (w_div_clamp) r_flag <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // result register with saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_zero) begin
                r_eps_re <= ACC_HI[OUT_W-1:0];
                r_eps_im <= '0;
                r_sat    <= 1'b1;
            end else begin
                if (r_acc_re > ACC_HI) begin
                    r_eps_re <= ACC_HI[OUT_W-1:0];
                end else if (r_acc_re < ACC_LO) begin
                    r_eps_re <= ACC_LO[OUT_W-1:0];
                end else begin
                    r_eps_re <= r_acc_re[OUT_W-1:0];
                end
                if (r_acc_im > ACC_HI) begin
                    r_eps_im <= ACC_HI[OUT_W-1:0];
                end else if (r_acc_im < ACC_LO) begin
                    r_eps_im <= ACC_LO[OUT_W-1:0];
                end else begin
                    r_eps_im <= r_acc_im[OUT_W-1:0];
                end
                r_sat <= r_flag || (r_acc_re > ACC_HI) || (r_acc_re < ACC_LO)
                      || (r_acc_im > ACC_HI) || (r_acc_im < ACC_LO);
            end
        end
    end

endmodule
